// ----- sv/apet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apet_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = $clog2(COORD_W);

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(COORD_W - 1);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;
    localparam int WHEEL_UP   = 3;
    localparam int WHEEL_DOWN = 4;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    localparam logic signed [7:0] WHEEL_STEP_UP   = 8'sd120;
    localparam logic signed [7:0] WHEEL_STEP_DOWN = -8'sd120;
    localparam logic signed [7:0] WHEEL_STEP_NONE = 8'sd0;

    typedef struct packed {
        logic [7:0]         button_mask;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] abs_x;
        logic [COORD_W-1:0] abs_y;
        logic [1:0]         left_event;
        logic [1:0]         middle_event;
        logic [1:0]         right_event;
        logic signed [7:0]  wheel_step;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_X,
        S_LOAD_Y,
        S_DIV_Y,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_x;
        logic load_y;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [1:0] button_event(input logic now, input logic last);
        logic [1:0] ev;
        if (now == last) begin
            ev = EV_NONE;
        end else if (now) begin
            ev = EV_PRESS;
        end else begin
            ev = EV_RELEASE;
        end
        return ev;
    endfunction

endpackage

`default_nettype wire

// ----- sv/apet_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apet_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire apet_pkg::t_dp_status i_status,
    output apet_pkg::t_dp_cmd        o_cmd
);
    import apet_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_DIV_X;
                end
            end
            S_DIV_X: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == STEP_LAST) begin
                    n_state = S_LOAD_Y;
                end
            end
            S_LOAD_Y: begin
                o_cmd.load_y = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV_Y;
            end
            S_DIV_Y: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == STEP_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/apet_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apet_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire apet_pkg::t_dp_cmd    i_cmd,
    input  wire apet_pkg::t_in_item   i_in_item,
    input  wire logic [apet_pkg::SIZE_W-1:0] i_screen_width,
    input  wire logic [apet_pkg::SIZE_W-1:0] i_screen_height,
    input  wire logic                 i_out_stall,
    output apet_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    output apet_pkg::t_out_item       o_out_item
);
    import apet_pkg::*;

    logic [2:0]          r_last_buttons;
    logic [COORD_W-1:0]  r_pos_y;
    logic [1:0]          r_left_ev, r_middle_ev, r_right_ev;
    logic signed [7:0]   r_wheel;
    logic [COORD_W-1:0]  r_abs_x;

    logic [SIZE_W-1:0]   r_div;
    logic [COORD_W-1:0]  r_rem;
    logic [COORD_W-1:0]  r_quo;
    logic                r_sat;

    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [COORD_W-1:0]   ld_pos;
    logic [SIZE_W-1:0]    ld_size;
    logic [SIZE_W-1:0]    ld_div;
    logic [2*COORD_W-1:0] ld_dividend;
    logic [COORD_W:0]     trial;
    logic                 trial_ge;
    logic [COORD_W-1:0]   quo_final;
    logic [7:0]           mask;

    assign mask = i_in_item.button_mask;

    // divider load: pos * 65535 = (pos << 16) - pos
    always_comb begin
        ld_pos      = i_cmd.load_x ? i_in_item.pos_x : r_pos_y;
        ld_size     = i_cmd.load_x ? i_screen_width : i_screen_height;
        ld_div      = (ld_size >= SIZE_W'(2)) ? ld_size - SIZE_W'(1) : SIZE_W'(1);
        ld_dividend = {ld_pos, {COORD_W{1'b0}}} - {{COORD_W{1'b0}}, ld_pos};
        trial       = {r_rem, r_quo[COORD_W-1]};
        trial_ge    = trial >= {1'b0, r_div};
        quo_final   = r_sat ? {COORD_W{1'b1}} : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_buttons <= '0;
        end else if (i_cmd.load_x) begin
            r_last_buttons <= mask[BTN_RIGHT:BTN_LEFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_pos_y     <= i_in_item.pos_y;
            r_left_ev   <= button_event(mask[BTN_LEFT], r_last_buttons[BTN_LEFT]);
            r_middle_ev <= button_event(mask[BTN_MIDDLE], r_last_buttons[BTN_MIDDLE]);
            r_right_ev  <= button_event(mask[BTN_RIGHT], r_last_buttons[BTN_RIGHT]);
            if (mask[WHEEL_UP]) begin
                r_wheel <= WHEEL_STEP_UP;
            end else if (mask[WHEEL_DOWN]) begin
                r_wheel <= WHEEL_STEP_DOWN;
            end else begin
                r_wheel <= WHEEL_STEP_NONE;
            end
        end
        if (i_cmd.load_y) begin
            r_abs_x <= quo_final;
        end
    end

    // restoring divider, one quotient bit per step; the upper half of the
    // dividend starts as the remainder, so a quotient past 16 bits saturates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x || i_cmd.load_y) begin
            r_div <= ld_div;
            r_rem <= ld_dividend[2*COORD_W-1:COORD_W];
            r_quo <= ld_dividend[COORD_W-1:0];
            r_sat <= ld_dividend[2*COORD_W-1:COORD_W] >= ld_div;
        end else if (i_cmd.step) begin
            r_rem <= trial_ge ? COORD_W'(trial - {1'b0, r_div}) : trial[COORD_W-1:0];
            r_quo <= {r_quo[COORD_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.abs_x        <= r_abs_x;
            r_out_item.abs_y        <= quo_final;
            r_out_item.left_event   <= r_left_ev;
            r_out_item.middle_event <= r_middle_ev;
            r_out_item.right_event  <= r_right_ev;
            r_out_item.wheel_step   <= r_wheel;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

`default_nettype wire

// ----- sv/absolute_pointer_event_translator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Turns a remote pointer beat (button mask, pixel x and y) into one result beat: x and y
// scaled to 0..65535 as pos*65535/(size-1), saturated at 65535, a press/release code for
// each of left, middle and right against the previous mask, and a wheel step of +120, -120
// or 0 (up wins when both bits are set). After acceptance, one shared restoring divider
// produces one quotient bit per cycle, first for x and then, after a y load state, for y;
// an output state then writes the result register. The next item is accepted the cycle
// after the result has been written, even while that result still waits on a stall, and
// none while one is in flight; a second result held behind a stall keeps the input
// stalled. Screen width and height are 16-bit registers at byte addresses 0 and 4
// (reset 1920 and 1080); sizes below two divide by one. Write them only while the
// block is idle.

module absolute_pointer_event_translator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire apet_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output apet_pkg::t_out_item       o_out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import apet_pkg::*;

    logic [SIZE_W-1:0] r_screen_width;
    logic [SIZE_W-1:0] r_screen_height;
    logic              cfg_wr;
    t_dp_cmd           cmd;
    t_dp_status        status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_screen_width <= pwdata[SIZE_W-1:0];
            end else begin
                r_screen_height <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HEIGHT) begin
            prdata = {{(32-SIZE_W){1'b0}}, r_screen_height};
        end else begin
            prdata = {{(32-SIZE_W){1'b0}}, r_screen_width};
        end
    end

    apet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    apet_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_in_item       (i_in_item),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_item)
    );

endmodule

`default_nettype wire
